// File: rtl/core/pmt_pkg.sv
package pmt_pkg;

    // Pointer coordinate width.
    localparam int COORD_BITS = 12;
    localparam int COORD_MAX  = (1 << COORD_BITS) - 1;

    // Configuration port.
    localparam int REG_W   = 13;
    localparam int APB_DW  = 32;
    localparam int APB_AW  = 3;

    typedef enum logic [0:0] {
        REG_SCREEN_WIDTH  = 1'b0,
        REG_SCREEN_HEIGHT = 1'b1
    } t_reg_idx;

    localparam logic [REG_W-1:0] SCREEN_WIDTH_INIT  = REG_W'(800);
    localparam logic [REG_W-1:0] SCREEN_HEIGHT_INIT = REG_W'(600);

    // Reset pointer position, saturated to the coordinate range.
    localparam int RESET_X = 400;
    localparam int RESET_Y = 300;
    localparam logic [COORD_BITS-1:0] POS_X_INIT =
        COORD_BITS'((RESET_X > COORD_MAX) ? COORD_MAX : RESET_X);
    localparam logic [COORD_BITS-1:0] POS_Y_INIT =
        COORD_BITS'((RESET_Y > COORD_MAX) ? COORD_MAX : RESET_Y);

    // Controller status and packet header bits.
    localparam logic [7:0] VALID_MASK = 8'h21;
    localparam int HDR_LEFT_BIT  = 0;
    localparam int HDR_RIGHT_BIT = 1;
    localparam int HDR_SYNC_BIT  = 3;
    localparam int HDR_XSIGN_BIT = 4;
    localparam int HDR_YSIGN_BIT = 5;

    // Scaling by 9/5: the divide by 5 is a multiply by a rounded-up reciprocal,
    // exact for magnitudes below 2^RECIP_SHIFT.
    localparam int SCALE_NUM   = 9;
    localparam int SCALE_DEN   = 5;
    localparam int RECIP_SHIFT = 14;
    localparam int RECIP_MUL   = ((1 << RECIP_SHIFT) + SCALE_DEN - 1) / SCALE_DEN;
    localparam int MAG_W       = 12;
    localparam int PROD_W      = MAG_W + RECIP_SHIFT;
    localparam int DELTA_W     = 11;

    // Signed width for position plus delta, and width for the limit math.
    localparam int SUM_W = ((COORD_BITS > DELTA_W) ? COORD_BITS : DELTA_W) + 2;
    localparam int LIM_W = (REG_W > COORD_BITS + 1) ? REG_W : COORD_BITS + 1;

    // Command queue between front and back; depth is a power of two.
    localparam int QDEPTH = 4;
    localparam int QA_W   = $clog2(QDEPTH);
    localparam int QC_W   = $clog2(QDEPTH + 1);

    typedef enum logic [1:0] {
        PH_HEADER = 2'd0,
        PH_XDELTA = 2'd1,
        PH_YDELTA = 2'd2
    } t_phase;

    typedef struct packed {
        logic       done;
        logic       left;
        logic       right;
        logic       x_sign;
        logic       y_sign;
        logic [7:0] x_byte;
        logic [7:0] y_byte;
    } t_cmd;

    typedef struct packed {
        logic                      done;
        logic                      left;
        logic                      right;
        logic signed [DELTA_W-1:0] dx;
        logic signed [DELTA_W-1:0] dy;
    } t_move;

    // 9-bit two's complement delta times 9/5, truncated toward zero.
    function automatic logic signed [DELTA_W-1:0] scale_delta(input logic       neg,
                                                              input logic [7:0] mag_byte);
        logic [8:0]         d;
        logic [8:0]         abs_d;
        logic [MAG_W-1:0]   m;
        logic [PROD_W-1:0]  p;
        logic [DELTA_W-1:0] q;
        d     = {neg, mag_byte};
        abs_d = neg ? (~d + 9'd1) : d;
        m     = MAG_W'(abs_d) * MAG_W'(SCALE_NUM);
        p     = PROD_W'(m) * PROD_W'(RECIP_MUL);
        q     = DELTA_W'(p >> RECIP_SHIFT);
        return $signed(neg ? (~q + DELTA_W'(1)) : q);
    endfunction

    // Largest coordinate allowed for a screen dimension.
    function automatic logic [COORD_BITS-1:0] dim_limit(input logic [REG_W-1:0] dim);
        logic [LIM_W-1:0] d;
        d = LIM_W'(dim);
        if (d == '0) begin
            d = LIM_W'(1);
        end
        if (d > (LIM_W'(1) << COORD_BITS)) begin
            d = LIM_W'(1) << COORD_BITS;
        end
        return COORD_BITS'(d - LIM_W'(1));
    endfunction

    function automatic logic [COORD_BITS-1:0] clamp_coord(input logic signed [SUM_W-1:0] v,
                                                          input logic [COORD_BITS-1:0] lim);
        logic [COORD_BITS-1:0] r;
        if (v < 0) begin
            r = '0;
        end else if (v > $signed(SUM_W'(lim))) begin
            r = lim;
        end else begin
            r = COORD_BITS'(v);
        end
        return r;
    endfunction

endpackage

// File: rtl/core/pmt_apb_regs.sv
module pmt_apb_regs
    import pmt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    output logic [COORD_BITS-1:0] o_lim_x,
    output logic [COORD_BITS-1:0] o_lim_y
);

    logic [REG_W-1:0] r_width;
    logic [REG_W-1:0] r_height;
    t_reg_idx         reg_idx;
    logic             wr_en;

    assign pready  = 1'b1;
    assign reg_idx = t_reg_idx'(paddr[2]);
    assign wr_en   = psel && penable && pwrite;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_width  <= SCREEN_WIDTH_INIT;
            r_height <= SCREEN_HEIGHT_INIT;
        end else if (wr_en) begin
            case (reg_idx)
                REG_SCREEN_WIDTH:  r_width  <= pwdata[REG_W-1:0];
                REG_SCREEN_HEIGHT: r_height <= pwdata[REG_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (reg_idx)
            REG_SCREEN_WIDTH:  prdata = APB_DW'(r_width);
            REG_SCREEN_HEIGHT: prdata = APB_DW'(r_height);
            default:           prdata = '0;
        endcase
    end

    assign o_lim_x = dim_limit(r_width);
    assign o_lim_y = dim_limit(r_height);

endmodule

// File: rtl/core/pmt_front.sv
module pmt_front
    import pmt_pkg::*;
(
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [7:0] i_ctrl_status,
    input  logic [7:0] i_data_byte,
    output logic       o_stall,
    input  logic       i_q_full,
    output logic       o_push,
    output t_cmd       o_cmd
);

    t_phase     r_phase;
    t_phase     n_phase;
    logic [7:0] r_header;
    logic [7:0] r_x_byte;
    logic       accept;
    logic       byte_ok;
    logic       hdr_load;
    logic       xb_load;

    assign o_stall = i_q_full;
    assign accept  = i_valid && !i_q_full;
    assign byte_ok = (i_ctrl_status & VALID_MASK) == VALID_MASK;

    always_comb begin
        n_phase = r_phase;
        if (accept && byte_ok) begin
            case (r_phase)
                PH_XDELTA: n_phase = PH_YDELTA;
                PH_YDELTA: n_phase = PH_HEADER;
                default: begin
                    // A header without the sync bit is dropped.
                    n_phase = i_data_byte[HDR_SYNC_BIT] ? PH_XDELTA : PH_HEADER;
                end
            endcase
        end
    end

    always_comb begin
        hdr_load      = 1'b0;
        xb_load       = 1'b0;
        o_cmd.done    = 1'b0;
        o_cmd.left    = r_header[HDR_LEFT_BIT];
        o_cmd.right   = r_header[HDR_RIGHT_BIT];
        o_cmd.x_sign  = r_header[HDR_XSIGN_BIT];
        o_cmd.y_sign  = r_header[HDR_YSIGN_BIT];
        o_cmd.x_byte  = r_x_byte;
        o_cmd.y_byte  = i_data_byte;
        if (accept && byte_ok) begin
            case (r_phase)
                PH_XDELTA: xb_load    = 1'b1;
                PH_YDELTA: o_cmd.done = 1'b1;
                default:   hdr_load   = i_data_byte[HDR_SYNC_BIT];
            endcase
        end
    end

    assign o_push = accept;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_HEADER;
        end else begin
            r_phase <= n_phase;
        end
    end

    always_ff @(posedge i_clk) begin
        if (hdr_load) begin
            r_header <= i_data_byte;
        end
        if (xb_load) begin
            r_x_byte <= i_data_byte;
        end
    end

endmodule

// File: rtl/core/pmt_queue.sv
module pmt_queue
    import pmt_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_data,
    output logic o_full,
    input  logic i_pop,
    output t_cmd o_data,
    output logic o_empty
);

    t_cmd            r_mem [QDEPTH];
    logic [QA_W-1:0] r_wr_ptr;
    logic [QA_W-1:0] r_rd_ptr;
    logic [QC_W-1:0] r_count;
    logic            do_push;
    logic            do_pop;

    assign o_full  = r_count == QC_W'(QDEPTH);
    assign o_empty = r_count == '0;
    assign o_data  = r_mem[r_rd_ptr];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wr_ptr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (do_push) begin
                r_wr_ptr <= r_wr_ptr + QA_W'(1);
            end
            if (do_pop) begin
                r_rd_ptr <= r_rd_ptr + QA_W'(1);
            end
            if (do_push && !do_pop) begin
                r_count <= r_count + QC_W'(1);
            end else if (do_pop && !do_push) begin
                r_count <= r_count - QC_W'(1);
            end
        end
    end

    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= QC_W'(QDEPTH))
        else $error("queue count exceeds depth");

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_push |-> !o_full)
        else $error("push into a full queue");

    a_push_grows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (do_push && !do_pop) |=> r_count == $past(r_count) + QC_W'(1))
        else $error("queue count did not grow on push");

endmodule

// File: rtl/core/pmt_back.sv
module pmt_back
    import pmt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_q_empty,
    input  t_cmd                  i_q_data,
    output logic                  o_pop,
    input  logic [COORD_BITS-1:0] i_lim_x,
    input  logic [COORD_BITS-1:0] i_lim_y,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_BITS-1:0] o_pointer_x,
    output logic [COORD_BITS-1:0] o_pointer_y,
    output logic                  o_left_button,
    output logic                  o_right_button,
    output logic                  o_packet_done
);

    // Stage 1: scaled deltas. Stage 2: position update and result register.
    logic                      r_s1_valid;
    t_move                     r_s1;
    t_move                     n_s1;
    logic                      r_out_valid;
    logic                      r_done;
    logic [COORD_BITS-1:0]     r_pos_x;
    logic [COORD_BITS-1:0]     r_pos_y;
    logic                      r_left;
    logic                      r_right;
    logic                      out_adv;
    logic                      s1_adv;
    logic signed [DELTA_W-1:0] dx;
    logic signed [DELTA_W-1:0] dy;
    logic signed [SUM_W-1:0]   sum_x;
    logic signed [SUM_W-1:0]   sum_y;

    assign out_adv = !r_out_valid || !i_stall;
    assign s1_adv  = !r_s1_valid || out_adv;
    assign o_pop   = s1_adv && !i_q_empty;

    always_comb begin
        n_s1.done  = i_q_data.done;
        n_s1.left  = i_q_data.left;
        n_s1.right = i_q_data.right;
        n_s1.dx    = scale_delta(i_q_data.x_sign, i_q_data.x_byte);
        n_s1.dy    = scale_delta(i_q_data.y_sign, i_q_data.y_byte);
    end

    assign dx    = r_s1.dx;
    assign dy    = r_s1.dy;
    assign sum_x = $signed(SUM_W'(r_pos_x)) + SUM_W'(dx);
    assign sum_y = $signed(SUM_W'(r_pos_y)) - SUM_W'(dy);

    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_s1 <= n_s1;
        end
        if (out_adv && r_s1_valid) begin
            r_done <= r_s1.done;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_valid  <= 1'b0;
            r_out_valid <= 1'b0;
            r_pos_x     <= POS_X_INIT;
            r_pos_y     <= POS_Y_INIT;
            r_left      <= 1'b0;
            r_right     <= 1'b0;
        end else begin
            if (s1_adv) begin
                r_s1_valid <= !i_q_empty;
            end
            if (out_adv) begin
                r_out_valid <= r_s1_valid;
            end
            // The position only moves when a finished packet enters the result register.
            if (out_adv && r_s1_valid && r_s1.done) begin
                r_pos_x <= clamp_coord(sum_x, i_lim_x);
                r_pos_y <= clamp_coord(sum_y, i_lim_y);
                r_left  <= r_s1.left;
                r_right <= r_s1.right;
            end
        end
    end

    assign o_valid        = r_out_valid;
    assign o_pointer_x    = r_pos_x;
    assign o_pointer_y    = r_pos_y;
    assign o_left_button  = r_left;
    assign o_right_button = r_right;
    assign o_packet_done  = r_done;

    a_s1_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_s1_valid && !out_adv) |=> r_s1_valid)
        else $error("stage 1 item lost while the result register was blocked");

    a_pop_fills: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |=> r_s1_valid)
        else $error("popped item did not reach stage 1");

    a_pos_stable: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && i_stall) |=> $stable(r_pos_x) && $stable(r_pos_y))
        else $error("pointer moved while its result was waiting");

endmodule

// File: rtl/core/ps2_mouse_packet_tracker_top.sv
// Path: an accepted item passes through the command queue, the delta scaling
// stage and the result register to reach the result port.
// Throughput: one item per cycle unless results stall; a four-entry queue
// accepts input while results stall; input stalls only when it is full.
// Reset is synchronous and active low: packet phase cleared, pointer at
// (400, 300), buttons released, screen 800 by 600, queue and result empty.
module ps2_mouse_packet_tracker_top
    import pmt_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_AW-1:0]     paddr,
    input  logic [APB_DW-1:0]     pwdata,
    output logic [APB_DW-1:0]     prdata,
    output logic                  pready,
    input  logic                  i_valid,
    output logic                  o_stall,
    input  logic [7:0]            i_ctrl_status,
    input  logic [7:0]            i_data_byte,
    output logic                  o_valid,
    input  logic                  i_stall,
    output logic [COORD_BITS-1:0] o_pointer_x,
    output logic [COORD_BITS-1:0] o_pointer_y,
    output logic                  o_left_button,
    output logic                  o_right_button,
    output logic                  o_packet_done
);

    logic [COORD_BITS-1:0] lim_x;
    logic [COORD_BITS-1:0] lim_y;
    logic                  q_full;
    logic                  q_empty;
    logic                  q_push;
    logic                  q_pop;
    t_cmd                  q_in;
    t_cmd                  q_out;

    pmt_apb_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_lim_x (lim_x),
        .o_lim_y (lim_y)
    );

    pmt_front u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (i_valid),
        .i_ctrl_status (i_ctrl_status),
        .i_data_byte   (i_data_byte),
        .o_stall       (o_stall),
        .i_q_full      (q_full),
        .o_push        (q_push),
        .o_cmd         (q_in)
    );

    pmt_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .o_full  (q_full),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    pmt_back u_back (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_q_empty      (q_empty),
        .i_q_data       (q_out),
        .o_pop          (q_pop),
        .i_lim_x        (lim_x),
        .i_lim_y        (lim_y),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pointer_x    (o_pointer_x),
        .o_pointer_y    (o_pointer_y),
        .o_left_button  (o_left_button),
        .o_right_button (o_right_button),
        .o_packet_done  (o_packet_done)
    );

endmodule

// File: tb/ps2_mouse_packet_tracker_top_test.sv
module ps2_mouse_packet_tracker_top_test;
    import pmt_pkg::*;

    typedef struct packed {
        logic [COORD_BITS-1:0] x;
        logic [COORD_BITS-1:0] y;
        logic                  left;
        logic                  right;
        logic                  done;
    } t_report;

    typedef struct packed {
        logic [7:0] st;
        logic [7:0] db;
        logic       typed;
        t_report    want;
    } t_row;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [APB_AW-1:0]     paddr;
    logic [APB_DW-1:0]     pwdata;
    logic [APB_DW-1:0]     prdata;
    logic                  pready;
    logic                  i_valid;
    logic                  o_stall;
    logic [7:0]            i_ctrl_status;
    logic [7:0]            i_data_byte;
    logic                  o_valid;
    logic                  i_stall;
    logic [COORD_BITS-1:0] o_pointer_x;
    logic [COORD_BITS-1:0] o_pointer_y;
    logic                  o_left_button;
    logic                  o_right_button;
    logic                  o_packet_done;

    ps2_mouse_packet_tracker_top u_top (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .psel           (psel),
        .penable        (penable),
        .pwrite         (pwrite),
        .paddr          (paddr),
        .pwdata         (pwdata),
        .prdata         (prdata),
        .pready         (pready),
        .i_valid        (i_valid),
        .o_stall        (o_stall),
        .i_ctrl_status  (i_ctrl_status),
        .i_data_byte    (i_data_byte),
        .o_valid        (o_valid),
        .i_stall        (i_stall),
        .o_pointer_x    (o_pointer_x),
        .o_pointer_y    (o_pointer_y),
        .o_left_button  (o_left_button),
        .o_right_button (o_right_button),
        .o_packet_done  (o_packet_done)
    );

    // Tracker state as the block should hold it.
    t_phase                trk_phase;
    logic [7:0]            hdr_seen;
    logic [7:0]            xbyte_seen;
    logic [COORD_BITS-1:0] cur_x;
    logic [COORD_BITS-1:0] cur_y;
    logic                  btn_l;
    logic                  btn_r;
    logic [REG_W-1:0]      scr_w;
    logic [REG_W-1:0]      scr_h;

    t_report pointer_reports[$];
    t_row    steps [0:23];
    int      miss_count;
    int      bytes_fed;
    bit      calm;

    initial begin
        i_clk = 1'b0;
        forever begin
            #5 i_clk = ~i_clk;
        end
    end

    initial begin
        #5000000;
        $display("CHECK FAILED");
        $finish;
    end

    function automatic int scaled_move(input logic [7:0] b, input logic neg);
        int d;
        d = int'(b);
        if (neg) begin
            d = d - 256;
        end
        // Integer division truncates toward zero, as the block must.
        return (d * SCALE_NUM) / SCALE_DEN;
    endfunction

    function automatic int screen_edge(input logic [REG_W-1:0] dim);
        int d;
        d = int'(dim);
        if (d == 0) begin
            d = 1;
        end
        if (d > COORD_MAX + 1) begin
            d = COORD_MAX + 1;
        end
        return d - 1;
    endfunction

    function automatic logic [COORD_BITS-1:0] pin_coord(input int v, input int lim);
        if (v < 0) begin
            v = 0;
        end
        if (v > lim) begin
            v = lim;
        end
        return COORD_BITS'(v);
    endfunction

    task automatic track_byte(input logic [7:0] st, input logic [7:0] db, output t_report r);
        int dx;
        int dy;
        r.done = 1'b0;
        if ((st & VALID_MASK) == VALID_MASK) begin
            case (trk_phase)
                PH_XDELTA: begin
                    xbyte_seen = db;
                    trk_phase  = PH_YDELTA;
                end
                PH_YDELTA: begin
                    dx     = scaled_move(xbyte_seen, hdr_seen[HDR_XSIGN_BIT]);
                    dy     = scaled_move(db, hdr_seen[HDR_YSIGN_BIT]);
                    cur_x  = pin_coord(int'(cur_x) + dx, screen_edge(scr_w));
                    cur_y  = pin_coord(int'(cur_y) - dy, screen_edge(scr_h));
                    btn_l  = hdr_seen[HDR_LEFT_BIT];
                    btn_r  = hdr_seen[HDR_RIGHT_BIT];
                    trk_phase = PH_HEADER;
                    r.done = 1'b1;
                end
                default: begin
                    trk_phase = PH_HEADER;
                    if (db[HDR_SYNC_BIT]) begin
                        hdr_seen  = db;
                        trk_phase = PH_XDELTA;
                    end
                end
            endcase
        end
        r.x     = cur_x;
        r.y     = cur_y;
        r.left  = btn_l;
        r.right = btn_r;
    endtask

    task automatic log_miss(input string msg);
        if (miss_count < 10) begin
            $display("%s", msg);
        end
        miss_count++;
    endtask

    // Presents one item and waits until the block takes it.
    task automatic send_item(input logic [7:0] st, input logic [7:0] db,
                             input logic typed, input t_report want);
        int      gap;
        t_report r;
        gap = 0;
        if (!calm && $urandom_range(0, 5) == 0) begin
            gap = $urandom_range(1, 11);
        end
        repeat (gap) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
        end
        @(negedge i_clk);
        i_valid       <= 1'b1;
        i_ctrl_status <= st;
        i_data_byte   <= db;
        do begin
            @(posedge i_clk);
        end while (o_stall);
        track_byte(st, db, r);
        pointer_reports.push_back(typed ? want : r);
        bytes_fed++;
    endtask

    task automatic apb_xfer(input logic wr, input t_reg_idx idx, input logic [APB_DW-1:0] wd,
                            output logic [APB_DW-1:0] rd);
        @(negedge i_clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= APB_AW'(4 * int'(idx));
        pwdata  <= wd;
        @(negedge i_clk);
        penable <= 1'b1;
        do begin
            @(posedge i_clk);
        end while (!pready);
        rd = prdata;
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic set_reg(input t_reg_idx idx, input logic [REG_W-1:0] v);
        logic [APB_DW-1:0] rd;
        apb_xfer(1'b1, idx, APB_DW'(v), rd);
        if (idx == REG_SCREEN_WIDTH) begin
            scr_w = v;
        end else begin
            scr_h = v;
        end
        apb_xfer(1'b0, idx, '0, rd);
        if (rd !== APB_DW'(v)) begin
            log_miss($sformatf("register %0d read back: expected %0d, got %0d",
                               int'(idx), v, rd));
        end
    endtask

    // Screen size changes only once every pending report has come back.
    task automatic set_screen(input logic [REG_W-1:0] w, input logic [REG_W-1:0] h);
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pointer_reports.size() != 0) begin
            @(posedge i_clk);
        end
        set_reg(REG_SCREEN_WIDTH, w);
        set_reg(REG_SCREEN_HEIGHT, h);
    endtask

    function automatic logic [7:0] good_status();
        return 8'($urandom) | VALID_MASK;
    endfunction

    function automatic logic [7:0] bad_status();
        logic [7:0] s;
        s = 8'($urandom);
        case ($urandom_range(0, 2))
            0: s[0] = 1'b0;
            1: s[5] = 1'b0;
            default: begin
                s[0] = 1'b0;
                s[5] = 1'b0;
            end
        endcase
        return s;
    endfunction

    function automatic logic [7:0] pick_delta();
        logic [7:0] b;
        b = 8'($urandom);
        if ($urandom_range(0, 4) == 0) begin
            case ($urandom_range(0, 4))
                0: b = 8'h00;
                1: b = 8'hFF;
                2: b = 8'h7F;
                3: b = 8'h80;
                default: b = 8'h01;
            endcase
        end
        return b;
    endfunction

    always @(posedge i_clk) begin
        t_report want;
        if (i_rst_n && o_valid && !i_stall) begin
            if (pointer_reports.size() == 0) begin
                log_miss($sformatf("report with none pending: x=%0d y=%0d l=%0d r=%0d done=%0d",
                                   o_pointer_x, o_pointer_y, o_left_button, o_right_button,
                                   o_packet_done));
            end else begin
                want = pointer_reports.pop_front();
                if (o_pointer_x !== want.x || o_pointer_y !== want.y
                    || o_left_button !== want.left || o_right_button !== want.right
                    || o_packet_done !== want.done) begin
                    log_miss($sformatf({"report mismatch: expected x=%0d y=%0d l=%0d r=%0d ",
                                        "done=%0d, got x=%0d y=%0d l=%0d r=%0d done=%0d"},
                                       want.x, want.y, want.left, want.right, want.done,
                                       o_pointer_x, o_pointer_y, o_left_button,
                                       o_right_button, o_packet_done));
                end
            end
        end
    end

    // Result side back-pressure in random bursts, off in the last part of the run.
    initial begin
        int n;
        i_stall = 1'b0;
        wait (i_rst_n);
        forever begin
            n = $urandom_range(1, 11);
            @(negedge i_clk);
            if (!calm && $urandom_range(0, 3) == 0) begin
                i_stall <= 1'b1;
            end else begin
                i_stall <= 1'b0;
            end
            repeat (n - 1) @(negedge i_clk);
        end
    end

    initial begin
        int         ph;
        int         k;
        int         pick;
        int         target;
        logic [7:0] hdr;
        i_rst_n       = 1'b0;
        psel          = 1'b0;
        penable       = 1'b0;
        pwrite        = 1'b0;
        paddr         = '0;
        pwdata        = '0;
        i_valid       = 1'b0;
        i_ctrl_status = '0;
        i_data_byte   = '0;
        miss_count    = 0;
        bytes_fed     = 0;
        calm          = 1'b0;
        trk_phase     = PH_HEADER;
        hdr_seen      = '0;
        xbyte_seen    = '0;
        cur_x         = POS_X_INIT;
        cur_y         = POS_Y_INIT;
        btn_l         = 1'b0;
        btn_r         = 1'b0;
        scr_w         = SCREEN_WIDTH_INIT;
        scr_h         = SCREEN_HEIGHT_INIT;

        // Rows with typed expectations assume the reset screen of 800 by 600.
        steps = '{
            '{8'h00, 8'hFF, 1'b1, '{12'd400, 12'd300, 1'b0, 1'b0, 1'b0}},
            '{8'h20, 8'h08, 1'b1, '{12'd400, 12'd300, 1'b0, 1'b0, 1'b0}},
            '{8'h01, 8'h08, 1'b1, '{12'd400, 12'd300, 1'b0, 1'b0, 1'b0}},
            '{8'h21, 8'h07, 1'b1, '{12'd400, 12'd300, 1'b0, 1'b0, 1'b0}},
            '{8'h21, 8'h0B, 1'b1, '{12'd400, 12'd300, 1'b0, 1'b0, 1'b0}},
            '{8'hFF, 8'hFF, 1'b1, '{12'd400, 12'd300, 1'b0, 1'b0, 1'b0}},
            '{8'h21, 8'h00, 1'b1, '{12'd799, 12'd300, 1'b1, 1'b1, 1'b1}},
            '{8'h21, 8'h38, 1'b1, '{12'd799, 12'd300, 1'b1, 1'b1, 1'b0}},
            '{8'h21, 8'h00, 1'b1, '{12'd799, 12'd300, 1'b1, 1'b1, 1'b0}},
            '{8'hE1, 8'h00, 1'b1, '{12'd339, 12'd599, 1'b0, 1'b0, 1'b1}},
            '{8'h21, 8'h39, 1'b0, '0},
            '{8'h21, 8'hFF, 1'b0, '0},
            '{8'h21, 8'hFF, 1'b0, '0},
            '{8'h21, 8'h18, 1'b0, '0},
            '{8'h1E, 8'h55, 1'b0, '0},
            '{8'h21, 8'h00, 1'b0, '0},
            '{8'h21, 8'h80, 1'b0, '0},
            '{8'h21, 8'h2A, 1'b0, '0},
            '{8'h21, 8'h7F, 1'b0, '0},
            '{8'h21, 8'h81, 1'b0, '0},
            '{8'h21, 8'hF7, 1'b0, '0},
            '{8'h21, 8'h08, 1'b0, '0},
            '{8'h21, 8'h00, 1'b0, '0},
            '{8'h21, 8'h00, 1'b0, '0}
        };

        repeat (11) @(negedge i_clk);
        i_rst_n <= 1'b1;

        for (k = 0; k < 24; k++) begin
            send_item(steps[k].st, steps[k].db, steps[k].typed, steps[k].want);
        end

        for (ph = 0; ph < 7; ph++) begin
            case (ph)
                1: set_screen(13'd1, 13'd1);
                2: set_screen(13'd4096, 13'd4096);
                3: set_screen(13'd0, 13'd8191);
                4: set_screen(13'd8191, 13'd0);
                5: set_screen(REG_W'($urandom_range(2, 300)), REG_W'($urandom_range(2, 300)));
                6: set_screen(13'd640, 13'd480);
                default: ;
            endcase
            if (ph == 6) begin
                calm = 1'b1;
            end
            target = bytes_fed + 250;
            while (bytes_fed < target) begin
                pick = $urandom_range(0, 99);
                if (pick < 75) begin
                    // Well-formed packet, now and then broken off or interleaved.
                    hdr = 8'($urandom);
                    hdr[HDR_SYNC_BIT] = 1'b1;
                    for (k = 0; k < 3; k++) begin
                        if ($urandom_range(0, 11) == 0) begin
                            send_item(bad_status(), 8'($urandom), 1'b0, '0);
                        end
                        if (k > 0 && $urandom_range(0, 39) == 0) begin
                            break;
                        end
                        send_item(good_status(), (k == 0) ? hdr : pick_delta(), 1'b0, '0);
                    end
                end else if (pick < 88) begin
                    send_item(good_status(), 8'($urandom), 1'b0, '0);
                end else begin
                    send_item(bad_status(), 8'($urandom), 1'b0, '0);
                end
            end
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (pointer_reports.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (8) @(posedge i_clk);
        if (miss_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

endmodule
